// ===== hw/rtl/tsc_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the scratchpad check unit.
`default_nettype none

package tsc_pkg;

   localparam int unsigned FRAME_BYTES_DEFAULT = 9;

   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam int unsigned RAW_W  = 16;
   localparam int unsigned FAHR_W = 17;

   // Frame summary handed from the frame tracker to the converter.
   typedef struct packed {
      logic                    crc_good;
      logic signed [RAW_W-1:0] raw_celsius;
   } frame_rsp_type;

   // One byte of the reflected CRC-8, least significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_cur,
                                            input logic [7:0] data);
      logic [7:0] crc;
      logic       fb;
      crc = crc_cur;
      for (int i = 0; i < 8; i++) begin
         fb  = crc[0] ^ data[i];
         crc = {1'b0, crc[7:1]};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsc_frame.sv =====
// Input register, byte counting, CRC accumulation and temperature byte capture.
`default_nettype none

module tsc_frame #(
   parameter int unsigned FRAME_BYTES = tsc_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_start,
   output logic                       frm_valid,
   input  wire logic                  frm_ready,
   output tsc_pkg::frame_rsp_type     frm_data
);

   localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

   logic                   hold_valid_ff;
   logic [7:0]             hold_byte_ff;
   logic                   hold_start_ff;

   logic [7:0]             crc_ff,   crc_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [7:0]             temp_low_ff,  temp_low_in;
   logic [7:0]             temp_high_ff, temp_high_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   tsc_pkg::frame_rsp_type rsp_ff, rsp_in;

   logic                   rsp_free;
   logic                   consume;
   logic [CNT_W-1:0]       idx;
   logic [7:0]             crc_next;
   logic                   last;

   assign rsp_free = !rsp_valid_ff || frm_ready;
   assign consume  = hold_valid_ff && rsp_free;
   assign in_ready = !hold_valid_ff || rsp_free;

   assign frm_valid = rsp_valid_ff;
   assign frm_data  = rsp_ff;

   always_comb begin
      idx          = hold_start_ff ? '0 : count_ff;
      crc_next     = tsc_pkg::crc8_byte(hold_start_ff ? 8'h00 : crc_ff, hold_byte_ff);
      last         = (idx == LAST_IDX);
      crc_in       = crc_ff;
      count_in     = count_ff;
      temp_low_in  = temp_low_ff;
      temp_high_in = temp_high_ff;
      rsp_valid_in = rsp_valid_ff && !frm_ready;
      rsp_in       = rsp_ff;
      if (consume) begin
         if (idx == CNT_W'(0)) begin
            temp_low_in = hold_byte_ff;
         end
         if (idx == CNT_W'(1)) begin
            temp_high_in = hold_byte_ff;
         end
         if (last) begin
            crc_in                = 8'h00;
            count_in              = '0;
            rsp_valid_in          = 1'b1;
            rsp_in.crc_good       = (crc_next == 8'h00);
            rsp_in.raw_celsius    = {temp_high_ff, temp_low_ff};
         end else begin
            crc_in   = crc_next;
            count_in = idx + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         crc_ff        <= 8'h00;
         count_ff      <= '0;
         temp_low_ff   <= 8'h00;
         temp_high_ff  <= 8'h00;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            hold_valid_ff <= in_valid;
         end
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         temp_low_ff  <= temp_low_in;
         temp_high_ff <= temp_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hold_byte_ff  <= in_byte;
         hold_start_ff <= in_start;
      end
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tsc_convert.sv =====
// Celsius to Fahrenheit conversion and the result register.
`default_nettype none

module tsc_convert (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                frm_valid,
   output logic                                     frm_ready,
   input  wire tsc_pkg::frame_rsp_type              frm_data,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output tsc_pkg::frame_rsp_type                   out_data,
   output logic signed [tsc_pkg::FAHR_W-1:0]        out_fahr
);

   // floor(m / 5) equals (m * RECIP5) >> DIV_SHIFT for every m below 2^22.
   localparam int unsigned PROD_W    = 20;
   localparam int unsigned DIV_SHIFT = 22;
   localparam logic [19:0] RECIP5    = 20'd838861;
   localparam logic [19:0] BIAS      = 20'd327680;
   localparam logic [17:0] OFFSET    = 18'd65024;

   logic                       valid_ff;
   tsc_pkg::frame_rsp_type     data_ff;
   logic signed [16:0]         fahr_ff, fahr_in;

   logic [PROD_W-1:0]          times9;
   logic [PROD_W-1:0]          biased;
   logic [2*PROD_W-1:0]        product;
   logic [17:0]                quot;

   assign frm_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_fahr  = fahr_ff;

   always_comb begin
      times9  = {{4{frm_data.raw_celsius[15]}}, frm_data.raw_celsius}
              + {frm_data.raw_celsius[15], frm_data.raw_celsius, 3'b000};
      biased  = times9 + BIAS;
      product = biased * RECIP5;
      quot    = product[DIV_SHIFT +: 18];
      if (frm_data.crc_good) begin
         fahr_in = 17'(quot - OFFSET);
      end else begin
         fahr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frm_ready) begin
         valid_ff <= frm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (frm_ready && frm_valid) begin
         data_ff <= frm_data;
         fahr_ff <= fahr_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/temp_sensor_scratchpad_check_unit.sv =====
// Top level of the one-wire temperature sensor scratchpad check unit.
`default_nettype none

// Takes one scratchpad byte per transaction and, on the last byte of each
// FRAME_BYTES-byte frame, returns one transaction with the CRC-8 status, the
// raw temperature and the temperature in sixteenths of a degree Fahrenheit.
// A new byte is accepted in every cycle unless rsp_tready holds results back;
// the last byte of a frame passes from the input register through the frame
// register and, after the reciprocal multiplier, the result register.
// Bytes that end no frame produce no result transaction.
module temp_sensor_scratchpad_check_unit #(
   parameter int unsigned FRAME_BYTES = tsc_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] raw_celsius, [32:16] fahrenheit_sixteenths
   output logic             rsp_tuser    // [0] crc_good
);

   logic                               frm_valid;
   logic                               frm_ready;
   tsc_pkg::frame_rsp_type             frm_data;
   tsc_pkg::frame_rsp_type             out_data;
   logic signed [tsc_pkg::FAHR_W-1:0]  out_fahr;

   tsc_frame #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_start  (req_tuser),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm_data  (frm_data)
   );

   tsc_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm_data  (frm_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .out_fahr  (out_fahr)
   );

   assign rsp_tdata = {7'b0000000, out_fahr, out_data.raw_celsius};
   assign rsp_tuser = out_data.crc_good;

endmodule

`default_nettype wire
